FILE: src/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH  = 1024;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SIZE       = 3'd4,
    OP_EMPTY      = 3'd5,
    OP_PEEK_FRONT = 3'd6,
    OP_PEEK_BACK  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // memory request for one operation
  typedef struct packed {
    logic          en;
    logic          wr;
    logic [AW-1:0] addr;
  } mem_req_t;

  // result fields known before the memory answers
  typedef struct packed {
    logic                     use_mem;
    logic signed [DATA_W-1:0] value;
    status_t                  status;
  } res_meta_t;

  // fold a sum below twice the depth back into the ring
  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
    logic [AW:0] depth_s;
    depth_s = (AW + 1)'(DEPTH);
    if (s >= depth_s) begin
      wrap_idx = AW'(s - depth_s);
    end else begin
      wrap_idx = AW'(s);
    end
  endfunction

endpackage

FILE: src/dq_in_if.sv
interface dq_in_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       opcode;
  logic signed [dq_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

FILE: src/dq_out_if.sv
interface dq_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dq_pkg::DATA_W-1:0] value;
  logic [1:0]                       status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: src/dq_ram.sv
module dq_ram #(
  parameter int DEPTH_P = 1024,
  parameter int WIDTH_P = 32,
  parameter int AW_P    = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic               clk,
  input  logic               en,
  input  logic               wr,
  input  logic [AW_P-1:0]    addr,
  input  logic [WIDTH_P-1:0] wdata,
  output logic [WIDTH_P-1:0] rdata_r
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

endmodule

FILE: src/dq_ptr.sv
module dq_ptr (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [2:0]        opcode,
  output dq_pkg::mem_req_t  mem_req,
  output dq_pkg::res_meta_t meta
);
  import dq_pkg::*;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          is_empty, is_full;
  logic [AW-1:0] head_dec, head_inc, tail_wr, tail_rd;
  logic [AW:0]   head_ext, count_ext;

  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(DEPTH));
  assign head_ext  = (AW + 1)'(head_r);
  assign count_ext = (AW + 1)'(count_r);
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_wr   = wrap_idx(head_ext + count_ext);
  assign tail_rd   = wrap_idx(head_ext + count_ext - (AW + 1)'(1));

  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    mem_req.en   = 1'b0;
    mem_req.wr   = 1'b0;
    mem_req.addr = head_r;
    meta.use_mem = 1'b0;
    meta.value   = '0;
    meta.status  = ST_OK;
    unique case (op_t'(opcode)) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (is_full) begin
          meta.status = ST_FULL;
        end else begin
          mem_req.en = 1'b1;
          mem_req.wr = 1'b1;
          count_nxt  = count_r + CW'(1);
          if (op_t'(opcode) == OP_PUSH_FRONT) begin
            mem_req.addr = head_dec;
            head_nxt     = head_dec;
          end else begin
            mem_req.addr = tail_wr;
          end
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT, OP_POP_BACK, OP_PEEK_BACK: begin
        if (is_empty) begin
          meta.value  = '1;
          meta.status = ST_EMPTY;
        end else begin
          mem_req.en   = 1'b1;
          meta.use_mem = 1'b1;
          if (op_t'(opcode) == OP_POP_FRONT || op_t'(opcode) == OP_PEEK_FRONT) begin
            mem_req.addr = head_r;
          end else begin
            mem_req.addr = tail_rd;
          end
          if (op_t'(opcode) == OP_POP_FRONT) begin
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
          end else if (op_t'(opcode) == OP_POP_BACK) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      OP_SIZE: begin
        meta.value = DATA_W'(count_r);
      end
      default: begin
        meta.value = is_empty ? DATA_W'(1) : '0;
      end
    endcase
    if (!accept) begin
      head_nxt   = head_r;
      count_nxt  = count_r;
      mem_req.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // count stays within the ring
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // a dropped push leaves the pointers alone
  a_full_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_full
      && (op_t'(opcode) == OP_PUSH_FRONT || op_t'(opcode) == OP_PUSH_BACK)
    |=> $stable(count_r) && $stable(head_r))
    else $error("push into full deque changed state");

  // a pop on an empty deque leaves the pointers alone
  a_empty_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_empty
      && (op_t'(opcode) == OP_POP_FRONT || op_t'(opcode) == OP_POP_BACK)
    |=> $stable(count_r) && $stable(head_r))
    else $error("pop on empty deque changed state");

endmodule

FILE: src/double_ended_queue.sv
// bounded double-ended queue of signed 32-bit words in a circular buffer
//
// in_ch carries one request per handshake: opcode and data_in. every request
// produces exactly one result on out_ch: value and status.
//   push front/back : value 0, status ok, or status full when the deque is full
//   pop/peek        : the word, or -1 with status empty when nothing is held
//   size / empty    : entry count / 1 when empty else 0, always status ok
// latency: the result is valid the cycle after the request is accepted.
// throughput: one request per cycle while out_ch keeps up; each request makes
// at most one access to the single-port entry memory, issued at the accepting
// edge, and the head and count registers update in that same edge.
// when out_ch stalls the result register holds and in_ch.ready drops until the
// held result is taken; a result taken in the same cycle frees the slot.
// reset (rst_n low, synchronous) empties the deque and drops any pending
// result; the memory contents are not cleared, only written entries are read.
module double_ended_queue (
  input logic      clk,
  input logic      rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  mem_req_t              mem_req;
  res_meta_t             meta;
  logic                  accept;
  logic [DATA_W-1:0]     rdata_r;

  // result register
  logic                  out_valid_r;
  logic                  use_mem_r;
  logic signed [DATA_W-1:0] value_r;
  status_t               status_r;

  // slot is free when empty or being drained this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  dq_ptr u_ptr (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .opcode  (in_ch.opcode),
    .mem_req (mem_req),
    .meta    (meta)
  );

  // entry store, read data lands next to the result register
  dq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (DATA_W),
    .AW_P    (AW)
  ) u_ram (
    .clk     (clk),
    .en      (mem_req.en),
    .wr      (mem_req.wr),
    .addr    (mem_req.addr),
    .wdata   (in_ch.data_in),
    .rdata_r (rdata_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= accept;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      use_mem_r <= meta.use_mem;
      value_r   <= meta.value;
      status_r  <= meta.status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = use_mem_r ? $signed(rdata_r) : value_r;
  assign out_ch.status = status_r;

  // empty status always comes with -1
  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EMPTY |-> out_ch.value == '1)
    else $error("empty status without -1 value");

  // memory data is only used for ok results
  a_mem_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && use_mem_r |-> status_r == ST_OK)
    else $error("memory result with error status");

  // a stalled memory result keeps the read data in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && use_mem_r && !out_ch.ready |=> $stable(rdata_r) && out_valid_r)
    else $error("read data lost under stall");

endmodule
